### src/ptlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlp_pkg
// Shared constants and register codes for the point-to-line projection block.
// ----------------------------------------------------------------------------
package ptlp_pkg;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int TQ_BITS      = 32;
  localparam int DIST_BITS    = 52;
  localparam int CFG_IDX_BITS = 3;
  localparam int FIFO_DEPTH   = 4;
  localparam int AXES         = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5
  } cfg_reg_t;

endpackage

### src/point_to_line_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_line_projection
// Projects 3-D points onto the line from start to end; returns t in Q16.16
// and the squared distance with 16 fraction bits.
// ----------------------------------------------------------------------------
// One point per clock unless out_tready stalls the output. An input beat
// passes 44 register stages: three front stages, one queue stage, 34 divider
// stages (load, 32 one-bit steps, saturate), five residual stages and the
// output register. The user must write line endpoints through the cfg port
// only while no points are in flight; the block does not enforce this. A line
// whose start equals its end returns zeros with the degenerate flag set.
module point_to_line_projection #(
  parameter int COORD_BITS = ptlp_pkg::COORD_BITS,
  parameter int FRAC_BITS  = ptlp_pkg::FRAC_BITS,
  localparam int IN_W  = ((ptlp_pkg::AXES * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((ptlp_pkg::TQ_BITS + ptlp_pkg::DIST_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,  // point_x, point_y, point_z
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_W-1:0]                  out_tdata, // line_param, dist_squared
  output logic                              out_tuser, // degenerate
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptlp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int NA   = ptlp_pkg::AXES;
  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int AW   = PW + 2;
  localparam int DENW = 2 * CB + 2;
  localparam int QB   = ptlp_pkg::TQ_BITS;
  localparam int DB   = ptlp_pkg::DIST_BITS;
  localparam int TW   = QB + DW;
  localparam int PSF  = DW + FB;
  localparam int EW   = ((TW > PSF) ? TW : PSF) + 1;
  localparam int SUMW = 2 * EW + 2;
  localparam int SW   = NA * DW;
  localparam int QW   = SW + 1 + AW;

  logic [CB-1:0]        start_r [NA];
  logic [CB-1:0]        end_r   [NA];
  logic signed [DW-1:0] d_r     [NA];
  logic signed [PW-1:0] dsq_r   [NA];
  logic [DENW-1:0]      den_r;
  logic                 deg;

  logic [NA*CB-1:0]     start_flat;
  logic [NA*DW-1:0]     d_flat;

  logic                 fq_valid, fq_full, fq_neg;
  logic [SW-1:0]        fq_ps;
  logic [AW-1:0]        fq_mag;
  logic [QW-1:0]        q_dout;
  logic                 q_empty;

  logic                 b_adv;
  logic                 dv_v;
  logic signed [QB-1:0] dv_t;
  logic [SW-1:0]        dv_ps;
  logic                 rs_v;
  logic signed [QB-1:0] rs_t;
  logic [SUMW-1:0]      rs_sum;
  logic [DB-1:0]        dist_c;

  logic                 out_tvalid_r;
  logic [QB-1:0]        line_r;
  logic [DB-1:0]        dist_r;
  logic                 deg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
      end_r[0] <= CB'(1);
    end else if (cfg_valid) begin
      case (ptlp_pkg::cfg_reg_t'(cfg_index))
        ptlp_pkg::REG_START_X: start_r[0] <= cfg_data;
        ptlp_pkg::REG_START_Y: start_r[1] <= cfg_data;
        ptlp_pkg::REG_START_Z: start_r[2] <= cfg_data;
        ptlp_pkg::REG_END_X:   end_r[0]   <= cfg_data;
        ptlp_pkg::REG_END_Y:   end_r[1]   <= cfg_data;
        ptlp_pkg::REG_END_Z:   end_r[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // line direction and its squared length, refreshed every cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      d_r[i]   <= DW'($signed(end_r[i])) - DW'($signed(start_r[i]));
      dsq_r[i] <= d_r[i] * d_r[i];
    end
    den_r <= DENW'(dsq_r[0]) + DENW'(dsq_r[1]) + DENW'(dsq_r[2]);
  end

  assign deg = (den_r == '0);

  genvar g;
  for (g = 0; g < NA; g++) begin : g_flat
    assign start_flat[g*CB +: CB] = start_r[g];
    assign d_flat[g*DW +: DW]     = d_r[g];
  end

  ptlp_front #(
    .CB (CB)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .pt_valid (in_tvalid),
    .pt_ready (in_tready),
    .pt_data  (in_tdata[NA*CB-1:0]),
    .start    (start_flat),
    .dir      (d_flat),
    .q_valid  (fq_valid),
    .q_full   (fq_full),
    .q_ps     (fq_ps),
    .q_neg    (fq_neg),
    .q_mag    (fq_mag)
  );

  ptlp_fifo #(
    .W     (QW),
    .DEPTH (ptlp_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_valid),
    .din   ({fq_ps, fq_neg, fq_mag}),
    .full  (fq_full),
    .pop   (b_adv),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign b_adv = !out_tvalid_r || out_tready;

  ptlp_div #(
    .CB (CB),
    .FB (FB),
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (b_adv),
    .in_v     (!q_empty),
    .in_neg   (q_dout[AW]),
    .in_mag   (q_dout[AW-1:0]),
    .in_side  (q_dout[QW-1:AW+1]),
    .den      (den_r),
    .out_v    (dv_v),
    .out_t    (dv_t),
    .out_side (dv_ps)
  );

  ptlp_resid #(
    .CB (CB),
    .FB (FB)
  ) u_resid (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (b_adv),
    .in_v    (dv_v),
    .in_t    (dv_t),
    .in_ps   (dv_ps),
    .dir     (d_flat),
    .out_v   (rs_v),
    .out_t   (rs_t),
    .out_sum (rs_sum)
  );

  assign dist_c = (|rs_sum[SUMW-1:FB+DB]) ? {DB{1'b1}} : rs_sum[FB+DB-1:FB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (b_adv) begin
      out_tvalid_r <= rs_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      line_r <= deg ? '0 : rs_t;
      dist_r <= deg ? '0 : dist_c;
      deg_r  <= deg;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({dist_r, line_r});
  assign out_tuser  = deg_r;

endmodule

### src/ptlp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlp_front
// Takes point beats, forms P-S and the dot product with the line direction,
// and hands sign and magnitude of the numerator to the queue.
// ----------------------------------------------------------------------------
module ptlp_front #(
  parameter int CB = ptlp_pkg::COORD_BITS,
  localparam int DW = CB + 1,
  localparam int PW = 2 * DW,
  localparam int AW = PW + 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pt_valid,
  output logic                                pt_ready,
  input  logic [ptlp_pkg::AXES*CB-1:0]        pt_data,
  input  logic [ptlp_pkg::AXES*CB-1:0]        start,
  input  logic [ptlp_pkg::AXES*DW-1:0]        dir,
  output logic                                q_valid,
  input  logic                                q_full,
  output logic [ptlp_pkg::AXES*DW-1:0]        q_ps,
  output logic                                q_neg,
  output logic [AW-1:0]                       q_mag
);

  localparam int NA = ptlp_pkg::AXES;

  logic                 f1_v_r, f2_v_r, f3_v_r;
  logic                 adv;
  logic signed [DW-1:0] ps_nxt  [NA];
  logic signed [DW-1:0] ps1_r   [NA];
  logic signed [DW-1:0] ps2_r   [NA];
  logic signed [DW-1:0] ps3_r   [NA];
  logic signed [PW-1:0] prod_r  [NA];
  logic signed [AW-1:0] num_c;
  logic                 neg_nxt;
  logic [AW-1:0]        mag_nxt;
  logic                 neg_r;
  logic [AW-1:0]        mag_r;

  assign adv      = !f3_v_r || !q_full;
  assign pt_ready = adv;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      ps_nxt[i] = DW'($signed(pt_data[i*CB +: CB])) - DW'($signed(start[i*CB +: CB]));
    end
    num_c   = AW'(prod_r[0]) + AW'(prod_r[1]) + AW'(prod_r[2]);
    neg_nxt = num_c[AW-1];
    mag_nxt = neg_nxt ? AW'(-num_c) : AW'(num_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= pt_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NA; i++) begin
        ps1_r[i]  <= ps_nxt[i];
        prod_r[i] <= ps1_r[i] * $signed(dir[i*DW +: DW]);
        ps2_r[i]  <= ps1_r[i];
        ps3_r[i]  <= ps2_r[i];
      end
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign q_valid = f3_v_r;
  assign q_neg   = neg_r;
  assign q_mag   = mag_r;

  genvar g;
  for (g = 0; g < NA; g++) begin : g_ps
    assign q_ps[g*DW +: DW] = ps3_r[g];
  end

endmodule

### src/ptlp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlp_fifo
// Short queue between the front and the back; lets each side stall alone.
// ----------------------------------------------------------------------------
module ptlp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = ptlp_pkg::FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PTRW-1:0] wr_r, rd_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTRW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTRW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

### src/ptlp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlp_div
// Pipelined restoring divider: one quotient bit per stage, giving t as
// signed fixed point, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module ptlp_div #(
  parameter int CB = ptlp_pkg::COORD_BITS,
  parameter int FB = ptlp_pkg::FRAC_BITS,
  parameter int SW = 8,
  localparam int AW   = 2 * (CB + 1) + 2,
  localparam int DENW = 2 * CB + 2,
  localparam int QB   = ptlp_pkg::TQ_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic                 in_neg,
  input  logic [AW-1:0]        in_mag,
  input  logic [SW-1:0]        in_side,
  input  logic [DENW-1:0]      den,
  output logic                 out_v,
  output logic signed [QB-1:0] out_t,
  output logic [SW-1:0]        out_side
);

  localparam int CW  = AW + QB;
  localparam int NXW = AW + FB + QB;

  logic              v_r    [QB+1];
  logic [DENW-1:0]   r_r    [QB+1];
  logic [QB-1:0]     n_r    [QB+1];
  logic [QB-1:0]     q_r    [QB+1];
  logic              neg_r  [QB+1];
  logic              ovf_r  [QB+1];
  logic [SW-1:0]     side_r [QB+1];

  logic [NXW-1:0]    nx;
  logic [CW-1:0]     den_sh;
  logic              ovf;
  logic [QB-1:0]     lim, m;
  logic signed [QB-1:0] t_nxt;

  logic                 tv_r;
  logic signed [QB-1:0] t_r;
  logic [SW-1:0]        tside_r;

  assign nx     = NXW'({in_mag, {FB{1'b0}}});
  assign den_sh = CW'(den) << (QB - FB);
  assign ovf    = CW'(in_mag) >= den_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= DENW'(nx >> QB);
      n_r[0]    <= nx[QB-1:0];
      q_r[0]    <= '0;
      neg_r[0]  <= in_neg;
      ovf_r[0]  <= ovf;
      side_r[0] <= in_side;
    end
  end

  genvar k;
  for (k = 1; k <= QB; k++) begin : g_step
    logic [DENW:0] rem2, diff;
    logic          ge;

    assign rem2 = {r_r[k-1], n_r[k-1][QB-1]};
    assign diff = rem2 - {1'b0, den};
    assign ge   = rem2 >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]    <= ge ? diff[DENW-1:0] : rem2[DENW-1:0];
        n_r[k]    <= n_r[k-1] << 1;
        q_r[k]    <= {q_r[k-1][QB-2:0], ge};
        neg_r[k]  <= neg_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_comb begin
    lim   = neg_r[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
    m     = (ovf_r[QB] || (q_r[QB] > lim)) ? lim : q_r[QB];
    t_nxt = neg_r[QB] ? $signed(-m) : $signed(m);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else if (en) begin
      tv_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= t_nxt;
      tside_r <= side_r[QB];
    end
  end

  assign out_v    = tv_r;
  assign out_t    = t_r;
  assign out_side = tside_r;

endmodule

### src/ptlp_resid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptlp_resid
// Residual P - S - t*(D-S) per axis and the sum of its squares, with each
// wide square split into partial products.
// ----------------------------------------------------------------------------
module ptlp_resid #(
  parameter int CB = ptlp_pkg::COORD_BITS,
  parameter int FB = ptlp_pkg::FRAC_BITS,
  localparam int DW   = CB + 1,
  localparam int QB   = ptlp_pkg::TQ_BITS,
  localparam int TW   = QB + DW,
  localparam int PSF  = DW + FB,
  localparam int EW   = ((TW > PSF) ? TW : PSF) + 1,
  localparam int SQW  = 2 * EW,
  localparam int SUMW = SQW + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic signed [QB-1:0]          in_t,
  input  logic [ptlp_pkg::AXES*DW-1:0]  in_ps,
  input  logic [ptlp_pkg::AXES*DW-1:0]  dir,
  output logic                          out_v,
  output logic signed [QB-1:0]          out_t,
  output logic [SUMW-1:0]               out_sum
);

  localparam int NA = ptlp_pkg::AXES;
  localparam int LW = EW / 2;
  localparam int HW = EW - LW;

  logic                  v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [QB-1:0]  t1_r, t2_r, t3_r, t4_r, t5_r;
  logic signed [TW-1:0]  prod1_r [NA];
  logic signed [DW-1:0]  ps1_r   [NA];
  logic signed [EW-1:0]  e_c     [NA];
  logic [EW-1:0]         ea2_r   [NA];
  logic [2*HW-1:0]       hh3_r   [NA];
  logic [HW+LW-1:0]      hl3_r   [NA];
  logic [2*LW-1:0]       ll3_r   [NA];
  logic [SQW-1:0]        sq4_r   [NA];
  logic [SUMW-1:0]       sum5_r;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      e_c[i] = (EW'(ps1_r[i]) <<< FB) - EW'(prod1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= in_t;
      t2_r <= t1_r;
      t3_r <= t2_r;
      t4_r <= t3_r;
      t5_r <= t4_r;
      for (int i = 0; i < NA; i++) begin
        prod1_r[i] <= in_t * $signed(dir[i*DW +: DW]);
        ps1_r[i]   <= $signed(in_ps[i*DW +: DW]);
        ea2_r[i]   <= e_c[i][EW-1] ? EW'(-e_c[i]) : EW'(e_c[i]);
        hh3_r[i]   <= ea2_r[i][EW-1:LW] * ea2_r[i][EW-1:LW];
        hl3_r[i]   <= ea2_r[i][EW-1:LW] * ea2_r[i][LW-1:0];
        ll3_r[i]   <= ea2_r[i][LW-1:0] * ea2_r[i][LW-1:0];
        sq4_r[i]   <= (SQW'(hh3_r[i]) << (2 * LW)) + (SQW'(hl3_r[i]) << (LW + 1))
                      + SQW'(ll3_r[i]);
      end
      sum5_r <= SUMW'(sq4_r[0]) + SUMW'(sq4_r[1]) + SUMW'(sq4_r[2]);
    end
  end

  assign out_v   = v5_r;
  assign out_t   = t5_r;
  assign out_sum = sum5_r;

endmodule
